### sv/cone_bounding_box_macros.svh
`ifndef CONE_BOUNDING_BOX_MACROS_SVH
`define CONE_BOUNDING_BOX_MACROS_SVH

// same-cycle implication, checked outside reset
`define CBB_ASSERT_IMPL(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("cone_bounding_box: same-cycle check failed");

// next-cycle implication, checked outside reset
`define CBB_ASSERT_NEXT(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("cone_bounding_box: next-cycle check failed");

`endif

### sv/cbb_pkg.sv
package cbb_pkg;

    localparam int FRAC_BITS = 16;
    localparam int COORD_W   = 32;
    localparam int LEN_W     = 31;

    // axis and base center
    localparam int MAG_W  = COORD_W;
    localparam int PROD_W = MAG_W + LEN_W - FRAC_BITS;
    localparam int PB_W   = PROD_W + 2;

    // extent: fraction divide then square root
    localparam int SQ_W     = 2 * MAG_W - 1;
    localparam int N_W      = SQ_W + 1;
    localparam int NN_W     = N_W - 2;
    localparam int FD_REM_W = NN_W + 1;
    localparam int T_W      = 2 * FRAC_BITS + 1;
    localparam int FD_ITERS = T_W;
    localparam int E_W      = FRAC_BITS + 1;
    localparam int ES_IN_W  = 2 * E_W;
    localparam int ES_ITERS = E_W;

    // radius: square root of cutoff then divide
    localparam int RX_W     = LEN_W + FRAC_BITS;
    localparam int RS_ITERS = (RX_W + 1) / 2;
    localparam int RS_W     = 2 * RS_ITERS;
    localparam int S_W      = RS_ITERS;
    localparam int RD_ITERS = RX_W;
    localparam int RDREM_W  = S_W + 1;
    localparam int R_W      = 34;
    localparam logic [R_W-1:0] R_MAX = R_W'(1) << (R_W - 1);

    localparam int OFF_W = E_W + R_W - FRAC_BITS;
    localparam int BND_W = PB_W + 1;

    // pipeline shape
    localparam int FRONT_STAGES = 1;
    localparam int MID_STAGES   = 18;
    localparam int BACK_STAGES  = 2;
    localparam int TOTAL_STAGES = FRONT_STAGES + MID_STAGES + BACK_STAGES;
    localparam int RS_STAGES    = 6;
    localparam int RD_STAGES    = MID_STAGES - RS_STAGES;
    localparam int FD_STAGES    = 11;
    localparam int ES_STAGES    = MID_STAGES - 1 - FD_STAGES;
    localparam int RS_STEPS     = (RS_ITERS + RS_STAGES - 1) / RS_STAGES;
    localparam int RD_STEPS     = (RD_ITERS + RD_STAGES - 1) / RD_STAGES;
    localparam int FD_STEPS     = (FD_ITERS + FD_STAGES - 1) / FD_STAGES;
    localparam int ES_STEPS     = (ES_ITERS + ES_STAGES - 1) / ES_STAGES;

    typedef logic [COORD_W-1:0] coord_t;

    typedef struct packed {
        coord_t [2:0]     apex;
        coord_t [2:0]     dir;
        logic [LEN_W-1:0] len;
        logic [LEN_W-1:0] rad;
        logic [LEN_W-1:0] cut;
    } cone_t;

    typedef struct packed {
        coord_t [2:0]           apex;
        logic [2:0][PROD_W-1:0] prod;
        logic [2:0]             neg;
        logic [2:0][SQ_W-1:0]   sq;
        logic [LEN_W-1:0]       rad;
        logic [LEN_W-1:0]       cut;
    } front_t;

    typedef struct packed {
        coord_t [2:0]         apex;
        logic [2:0][PB_W-1:0] pb;
    } geo_t;

    typedef struct packed {
        coord_t [2:0] lo;
        coord_t [2:0] hi;
    } box_t;

endpackage

### sv/cbb_if.sv
interface cbb_in_if import cbb_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] apex_x;
    logic signed [COORD_W-1:0] apex_y;
    logic signed [COORD_W-1:0] apex_z;
    logic signed [COORD_W-1:0] axis_dir_x;
    logic signed [COORD_W-1:0] axis_dir_y;
    logic signed [COORD_W-1:0] axis_dir_z;
    logic [LEN_W-1:0]          cone_length;
    logic [LEN_W-1:0]          light_radius;
    logic [LEN_W-1:0]          cutoff_value;

    modport source (
        output valid, apex_x, apex_y, apex_z, axis_dir_x, axis_dir_y, axis_dir_z,
               cone_length, light_radius, cutoff_value,
        input  ready
    );
    modport sink (
        input  valid, apex_x, apex_y, apex_z, axis_dir_x, axis_dir_y, axis_dir_z,
               cone_length, light_radius, cutoff_value,
        output ready
    );
endinterface

interface cbb_out_if import cbb_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] box_min_x;
    logic signed [COORD_W-1:0] box_min_y;
    logic signed [COORD_W-1:0] box_min_z;
    logic signed [COORD_W-1:0] box_max_x;
    logic signed [COORD_W-1:0] box_max_y;
    logic signed [COORD_W-1:0] box_max_z;

    modport source (
        output valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
        input  ready
    );
    modport sink (
        input  valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
        output ready
    );
endinterface

### sv/cbb_front.sv
module cbb_front import cbb_pkg::*;
(
    input  logic   clk,
    input  logic   move,
    input  cone_t  cone,
    output front_t front
);

    front_t front_next;
    front_t front_reg;

    always_comb
    begin
        logic [MAG_W-1:0]       mag;
        logic [MAG_W+LEN_W-1:0] p;
        logic [2*MAG_W-1:0]     s;
        front_next.apex = cone.apex;
        front_next.rad  = cone.rad;
        front_next.cut  = cone.cut;
        for (int l = 0; l < 3; l++)
        begin
            mag = cone.dir[l][COORD_W-1] ? (~cone.dir[l] + 1'b1) : cone.dir[l];
            p   = mag * cone.len;
            s   = mag * mag;
            front_next.prod[l] = p[MAG_W+LEN_W-1:FRAC_BITS];
            front_next.neg[l]  = cone.dir[l][COORD_W-1];
            front_next.sq[l]   = s[SQ_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (move)
        begin
            front_reg <= front_next;
        end
    end

    assign front = front_reg;

endmodule

### sv/cbb_radius.sv
module cbb_radius import cbb_pkg::*;
(
    input  logic                  clk,
    input  logic [MID_STAGES-1:0] move,
    input  logic [LEN_W-1:0]      rad,
    input  logic [LEN_W-1:0]      cut,
    output logic [R_W-1:0]        r
);

    logic [RS_W-1:0]    rs_num_reg [RS_STAGES-1];
    logic [RS_W-1:0]    rs_res_reg [RS_STAGES];
    logic [LEN_W-1:0]   rs_rad_reg [RS_STAGES];

    logic [RDREM_W-1:0] rd_rem_reg [RD_STAGES-1];
    logic [RX_W-1:0]    rd_dvd_reg [RD_STAGES-1];
    logic [RX_W-1:0]    rd_q_reg   [RD_STAGES];
    logic [S_W-1:0]     rd_den_reg [RD_STAGES];

    // square root of the cutoff, a few bit pairs per stage
    for (genvar k = 0; k < RS_STAGES; k++)
    begin : g_rs
        logic [RS_W-1:0]  num_in;
        logic [RS_W-1:0]  res_in;
        logic [LEN_W-1:0] rad_in;
        logic [RS_W-1:0]  num_next;
        logic [RS_W-1:0]  res_next;

        if (k == 0)
        begin : g_src
            assign num_in = RS_W'({cut, {FRAC_BITS{1'b0}}});
            assign res_in = '0;
            assign rad_in = rad;
        end
        else
        begin : g_src
            assign num_in = rs_num_reg[k-1];
            assign res_in = rs_res_reg[k-1];
            assign rad_in = rs_rad_reg[k-1];
        end

        always_comb
        begin
            int              j;
            logic [RS_W-1:0] bitv;
            num_next = num_in;
            res_next = res_in;
            for (int s = 0; s < RS_STEPS; s++)
            begin
                j = k * RS_STEPS + s;
                if (j < RS_ITERS)
                begin
                    bitv = RS_W'(1) << (RS_W - 2 - 2 * j);
                    if (num_next >= res_next + bitv)
                    begin
                        num_next = num_next - (res_next + bitv);
                        res_next = (res_next >> 1) + bitv;
                    end
                    else
                    begin
                        res_next = res_next >> 1;
                    end
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (move[k])
            begin
                rs_res_reg[k] <= res_next;
                rs_rad_reg[k] <= rad_in;
            end
        end

        if (k < RS_STAGES - 1)
        begin : g_num
            always_ff @(posedge clk)
            begin
                if (move[k])
                begin
                    rs_num_reg[k] <= num_next;
                end
            end
        end
    end

    // restoring divide of the shifted radius by the root
    for (genvar k = 0; k < RD_STAGES; k++)
    begin : g_rd
        logic [RDREM_W-1:0] rem_in;
        logic [RX_W-1:0]    dvd_in;
        logic [RX_W-1:0]    q_in;
        logic [S_W-1:0]     den_in;
        logic [RDREM_W-1:0] rem_next;
        logic [RX_W-1:0]    dvd_next;
        logic [RX_W-1:0]    q_next;

        if (k == 0)
        begin : g_src
            assign rem_in = '0;
            assign dvd_in = {rs_rad_reg[RS_STAGES-1], {FRAC_BITS{1'b0}}};
            assign q_in   = '0;
            assign den_in = rs_res_reg[RS_STAGES-1][S_W-1:0];
        end
        else
        begin : g_src
            assign rem_in = rd_rem_reg[k-1];
            assign dvd_in = rd_dvd_reg[k-1];
            assign q_in   = rd_q_reg[k-1];
            assign den_in = rd_den_reg[k-1];
        end

        always_comb
        begin
            int j;
            rem_next = rem_in;
            dvd_next = dvd_in;
            q_next   = q_in;
            for (int s = 0; s < RD_STEPS; s++)
            begin
                j = k * RD_STEPS + s;
                if (j < RD_ITERS)
                begin
                    rem_next = {rem_next[RDREM_W-2:0], dvd_next[RX_W-1]};
                    dvd_next = dvd_next << 1;
                    q_next   = q_next << 1;
                    if (rem_next >= RDREM_W'(den_in))
                    begin
                        rem_next  = rem_next - RDREM_W'(den_in);
                        q_next[0] = 1'b1;
                    end
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (move[RS_STAGES+k])
            begin
                rd_q_reg[k]   <= q_next;
                rd_den_reg[k] <= den_in;
            end
        end

        if (k < RD_STAGES - 1)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                if (move[RS_STAGES+k])
                begin
                    rd_rem_reg[k] <= rem_next;
                    rd_dvd_reg[k] <= dvd_next;
                end
            end
        end
    end

    // zero root means zero cutoff; clamp large radii
    always_comb
    begin
        priority if (rd_den_reg[RD_STAGES-1] == '0)
            r = '0;
        else if (rd_q_reg[RD_STAGES-1] > RX_W'(R_MAX))
            r = R_MAX;
        else
            r = rd_q_reg[RD_STAGES-1][R_W-1:0];
    end

endmodule

### sv/cbb_extent.sv
module cbb_extent import cbb_pkg::*;
(
    input  logic                  clk,
    input  logic [MID_STAGES-1:0] move,
    input  front_t                front,
    output logic [2:0][E_W-1:0]   e,
    output geo_t                  geo
);

    logic [N_W-1:0]               n;
    logic [2:0][N_W-1:0]          q;
    logic                         zero_axis;
    logic                         big;
    logic [NN_W-1:0]              prep_den;
    logic [2:0][FD_REM_W-1:0]     prep_rem;
    geo_t                         prep_geo;

    logic [2:0][FD_REM_W-1:0]     fd_rem_reg [FD_STAGES];
    logic [NN_W-1:0]              fd_den_reg [FD_STAGES];
    logic [2:0][T_W-1:0]          fd_t_reg   [FD_STAGES+1];
    geo_t                         geo_reg    [MID_STAGES];
    logic [2:0][ES_IN_W-1:0]      es_num_reg [ES_STAGES-1];
    logic [2:0][ES_IN_W-1:0]      es_res_reg [ES_STAGES];

    // norm, scaled numerators and base center
    always_comb
    begin
        n = N_W'(front.sq[0]) + N_W'(front.sq[1]) + N_W'(front.sq[2]);
        zero_axis = (front.prod == '0);
        big = (n[N_W-1:NN_W] != '0);
        prep_den = big ? n[N_W-1:2] : n[NN_W-1:0];
        for (int l = 0; l < 3; l++)
        begin
            q[l] = n - N_W'(front.sq[l]);
            prep_rem[l] = FD_REM_W'(big ? q[l][N_W-1:2] : q[l][NN_W-1:0]);
            if (zero_axis)
            begin
                prep_rem[l] = '0;
            end
            prep_geo.apex[l] = front.apex[l];
            prep_geo.pb[l]   = PB_W'($signed(front.apex[l]))
                             + (front.neg[l] ? -PB_W'(front.prod[l]) : PB_W'(front.prod[l]));
        end
        if (zero_axis)
        begin
            prep_den = NN_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (move[0])
        begin
            fd_rem_reg[0] <= prep_rem;
            fd_den_reg[0] <= prep_den;
            fd_t_reg[0]   <= '0;
            geo_reg[0]    <= prep_geo;
        end
    end

    for (genvar i = 1; i < MID_STAGES; i++)
    begin : g_geo
        always_ff @(posedge clk)
        begin
            if (move[i])
            begin
                geo_reg[i] <= geo_reg[i-1];
            end
        end
    end

    // fraction divide: integer bit first, then one fraction bit per step
    for (genvar k = 0; k < FD_STAGES; k++)
    begin : g_fd
        logic [2:0][FD_REM_W-1:0] rem_next;
        logic [2:0][T_W-1:0]      t_next;

        always_comb
        begin
            int j;
            rem_next = fd_rem_reg[k];
            t_next   = fd_t_reg[k];
            for (int l = 0; l < 3; l++)
            begin
                for (int s = 0; s < FD_STEPS; s++)
                begin
                    j = k * FD_STEPS + s;
                    if (j < FD_ITERS)
                    begin
                        if (j != 0)
                        begin
                            rem_next[l] = rem_next[l] << 1;
                            t_next[l]   = t_next[l] << 1;
                        end
                        if (rem_next[l] >= FD_REM_W'(fd_den_reg[k]))
                        begin
                            rem_next[l]  = rem_next[l] - FD_REM_W'(fd_den_reg[k]);
                            t_next[l][0] = 1'b1;
                        end
                    end
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (move[1+k])
            begin
                fd_t_reg[k+1] <= t_next;
            end
        end

        if (k < FD_STAGES - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (move[1+k])
                begin
                    fd_rem_reg[k+1] <= rem_next;
                    fd_den_reg[k+1] <= fd_den_reg[k];
                end
            end
        end
    end

    // square root of each ratio
    for (genvar k = 0; k < ES_STAGES; k++)
    begin : g_es
        logic [2:0][ES_IN_W-1:0] num_in;
        logic [2:0][ES_IN_W-1:0] res_in;
        logic [2:0][ES_IN_W-1:0] num_next;
        logic [2:0][ES_IN_W-1:0] res_next;

        if (k == 0)
        begin : g_src
            for (genvar l = 0; l < 3; l++)
            begin : g_lane
                assign num_in[l] = ES_IN_W'(fd_t_reg[FD_STAGES][l]);
            end
            assign res_in = '0;
        end
        else
        begin : g_src
            assign num_in = es_num_reg[k-1];
            assign res_in = es_res_reg[k-1];
        end

        always_comb
        begin
            int                 j;
            logic [ES_IN_W-1:0] bitv;
            num_next = num_in;
            res_next = res_in;
            for (int l = 0; l < 3; l++)
            begin
                for (int s = 0; s < ES_STEPS; s++)
                begin
                    j = k * ES_STEPS + s;
                    if (j < ES_ITERS)
                    begin
                        bitv = ES_IN_W'(1) << (ES_IN_W - 2 - 2 * j);
                        if (num_next[l] >= res_next[l] + bitv)
                        begin
                            num_next[l] = num_next[l] - (res_next[l] + bitv);
                            res_next[l] = (res_next[l] >> 1) + bitv;
                        end
                        else
                        begin
                            res_next[l] = res_next[l] >> 1;
                        end
                    end
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (move[1+FD_STAGES+k])
            begin
                es_res_reg[k] <= res_next;
            end
        end

        if (k < ES_STAGES - 1)
        begin : g_num
            always_ff @(posedge clk)
            begin
                if (move[1+FD_STAGES+k])
                begin
                    es_num_reg[k] <= num_next;
                end
            end
        end
    end

    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            e[l] = es_res_reg[ES_STAGES-1][l][E_W-1:0];
        end
    end

    assign geo = geo_reg[MID_STAGES-1];

endmodule

### sv/cbb_back.sv
module cbb_back import cbb_pkg::*;
(
    input  logic                   clk,
    input  logic [BACK_STAGES-1:0] move,
    input  logic [2:0][E_W-1:0]    e,
    input  logic [R_W-1:0]         r,
    input  geo_t                   geo,
    output box_t                   box
);

    localparam logic signed [BND_W-1:0] SAT_HI = BND_W'(2147483647);
    localparam logic signed [BND_W-1:0] SAT_LO = -SAT_HI - BND_W'(1);

    logic [2:0][OFF_W-1:0] off_next;
    logic [2:0][OFF_W-1:0] off_reg;
    geo_t                  geo_reg;
    box_t                  box_next;
    box_t                  box_reg;

    function automatic coord_t sat(input logic signed [BND_W-1:0] v);
        coord_t res;
        priority if (v > SAT_HI)
            res = SAT_HI[COORD_W-1:0];
        else if (v < SAT_LO)
            res = SAT_LO[COORD_W-1:0];
        else
            res = v[COORD_W-1:0];
        return res;
    endfunction

    always_comb
    begin
        logic [E_W+R_W-1:0] p;
        for (int l = 0; l < 3; l++)
        begin
            p = e[l] * r;
            off_next[l] = p[E_W+R_W-1:FRAC_BITS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (move[0])
        begin
            off_reg <= off_next;
            geo_reg <= geo;
        end
    end

    // widen the disk around the base center, then take in the apex
    always_comb
    begin
        logic signed [BND_W-1:0] pbx;
        logic signed [BND_W-1:0] apx;
        logic signed [BND_W-1:0] offx;
        logic signed [BND_W-1:0] lo;
        logic signed [BND_W-1:0] hi;
        for (int l = 0; l < 3; l++)
        begin
            pbx  = BND_W'($signed(geo_reg.pb[l]));
            apx  = BND_W'($signed(geo_reg.apex[l]));
            offx = BND_W'(off_reg[l]);
            lo   = pbx - offx;
            hi   = pbx + offx;
            if (apx < lo)
            begin
                lo = apx;
            end
            if (apx > hi)
            begin
                hi = apx;
            end
            box_next.lo[l] = sat(lo);
            box_next.hi[l] = sat(hi);
        end
    end

    always_ff @(posedge clk)
    begin
        if (move[1])
        begin
            box_reg <= box_next;
        end
    end

    assign box = box_reg;

endmodule

### sv/cone_bounding_box.sv
// Throughput: one item per cycle while the output is not stalled by box.ready;
// each of the 21 stages holds one item.
// The depth is set by the radius path: cutoff square root then the radius divide,
// 18 stages at four iterations each, with the extent divide and root beside it.
// Reset clears the stage valid bits only; payload registers are not reset.
`include "cone_bounding_box_macros.svh"

module cone_bounding_box import cbb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    cbb_in_if.sink    cone,
    cbb_out_if.source box
);

    cone_t                     cone_item;
    front_t                    front;
    geo_t                      geo;
    logic [2:0][E_W-1:0]       e;
    logic [R_W-1:0]            r;
    box_t                      box_item;
    logic [TOTAL_STAGES-1:0]   valid_reg;
    logic [TOTAL_STAGES-1:0]   move;

    assign cone_item.apex[0] = cone.apex_x;
    assign cone_item.apex[1] = cone.apex_y;
    assign cone_item.apex[2] = cone.apex_z;
    assign cone_item.dir[0]  = cone.axis_dir_x;
    assign cone_item.dir[1]  = cone.axis_dir_y;
    assign cone_item.dir[2]  = cone.axis_dir_z;
    assign cone_item.len     = cone.cone_length;
    assign cone_item.rad     = cone.light_radius;
    assign cone_item.cut     = cone.cutoff_value;

    // a stage advances when it is empty or the stage after it advances
    assign move[TOTAL_STAGES-1] = !valid_reg[TOTAL_STAGES-1] || box.ready;
    for (genvar k = 0; k < TOTAL_STAGES - 1; k++)
    begin : g_move
        assign move[k] = !valid_reg[k] || move[k+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (move[0])
            begin
                valid_reg[0] <= cone.valid;
            end
            for (int k = 1; k < TOTAL_STAGES; k++)
            begin
                if (move[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    cbb_front u_front (
        .clk   (clk),
        .move  (move[0]),
        .cone  (cone_item),
        .front (front)
    );

    cbb_radius u_radius (
        .clk  (clk),
        .move (move[FRONT_STAGES +: MID_STAGES]),
        .rad  (front.rad),
        .cut  (front.cut),
        .r    (r)
    );

    cbb_extent u_extent (
        .clk   (clk),
        .move  (move[FRONT_STAGES +: MID_STAGES]),
        .front (front),
        .e     (e),
        .geo   (geo)
    );

    cbb_back u_back (
        .clk  (clk),
        .move (move[FRONT_STAGES+MID_STAGES +: BACK_STAGES]),
        .e    (e),
        .r    (r),
        .geo  (geo),
        .box  (box_item)
    );

    assign cone.ready    = move[0];
    assign box.valid     = valid_reg[TOTAL_STAGES-1];
    assign box.box_min_x = box_item.lo[0];
    assign box.box_min_y = box_item.lo[1];
    assign box.box_min_z = box_item.lo[2];
    assign box.box_max_x = box_item.hi[0];
    assign box.box_max_y = box_item.hi[1];
    assign box.box_max_z = box_item.hi[2];

    `CBB_ASSERT_IMPL(a_ready_when_drained, clk, rst_n, !box.valid || box.ready, cone.ready)
    `CBB_ASSERT_NEXT(a_occupancy, clk, rst_n, 1'b1, $countones(valid_reg) == $past($countones(valid_reg)) + int'($past(cone.valid && cone.ready)) - int'($past(box.valid && box.ready)))
    `CBB_ASSERT_IMPL(a_box_ordered, clk, rst_n, box.valid, ($signed(box.box_min_x) <= $signed(box.box_max_x)) && ($signed(box.box_min_y) <= $signed(box.box_max_y)) && ($signed(box.box_min_z) <= $signed(box.box_max_z)))

endmodule
